### rtl/core/glu_pkg.sv
// shared types and constants for the gcd / lcm unit
`default_nettype none
package glu_pkg;

   localparam int DataWidth = 64;
   localparam int CntWidth  = 6;

   typedef logic [DataWidth-1:0] word_type;
   typedef logic [CntWidth-1:0]  cnt_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIV,
      ST_PREP,
      ST_MUL,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic gcd_step;
      logic gcd_fin;
      logic div_step;
      logic mul_init;
      logic mul_step;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic gcd_done;
      logic lcm_path;
      logic cnt_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

### rtl/core/glu_ctrl.sv
// sequencer for the binary gcd, quotient and product phases
`default_nettype none
module glu_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire glu_pkg::status_type sts,
   output glu_pkg::cmd_type        cmd
);
   import glu_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_GCD;
         end
         ST_GCD: begin
            if (sts.gcd_done) state_in = sts.lcm_path ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            if (sts.cnt_last) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (sts.cnt_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // input stays closed while reset is held
            req_tready = !reset;
            cmd.load   = req_tvalid && !reset;
         end
         ST_GCD: begin
            cmd.gcd_step = !sts.gcd_done;
            cmd.gcd_fin  = sts.gcd_done;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_PREP: begin
            cmd.mul_init = 1'b1;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
         end
         ST_DONE: begin
            cmd.emit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/core/glu_datapath.sv
// operand registers, shift-subtract gcd, restoring divider, shift-add multiplier
`default_nettype none
module glu_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire glu_pkg::cmd_type    cmd,
   output glu_pkg::status_type      sts,
   input  wire logic                req_kind,
   input  wire glu_pkg::word_type   req_operand_a,
   input  wire glu_pkg::word_type   req_operand_b,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output glu_pkg::word_type        rsp_value,
   output logic                     rsp_overflow
);
   import glu_pkg::*;

   word_type a_ff, a_in;
   word_type b_ff, b_in;
   word_type x_ff, x_in;
   word_type y_ff, y_in;
   word_type g_ff, g_in;
   cnt_type  k_ff, k_in;
   cnt_type  cnt_ff, cnt_in;
   logic     kind_ff, kind_in;
   logic     nz_ff, nz_in;
   logic     neg_ff, neg_in;
   word_type value_ff, value_in;
   logic     ovf_ff, ovf_in;
   logic     valid_ff, valid_in;

   word_type         mag_a, mag_b;
   logic [DataWidth:0] rem_sh, rem_diff, mul_sum;
   logic             qbit;
   word_type         diff_xy, diff_yx;
   logic             prod_neg_ovf;

   assign mag_a = req_operand_a[DataWidth-1] ? word_type'(-req_operand_a) : req_operand_a;
   assign mag_b = req_operand_b[DataWidth-1] ? word_type'(-req_operand_b) : req_operand_b;

   assign diff_xy = x_ff - y_ff;
   assign diff_yx = y_ff - x_ff;

   // one restoring division bit per cycle, dividend shifts out of a_ff
   assign rem_sh   = {y_ff, a_ff[DataWidth-1]};
   assign rem_diff = rem_sh - {1'b0, g_ff};
   assign qbit     = !rem_diff[DataWidth];

   // multiplier in b_ff shifts right while low product bits fill from the top
   assign mul_sum = {1'b0, y_ff} + (b_ff[0] ? {1'b0, x_ff} : '0);

   // magnitude above 2^63 cannot be negated into range
   assign prod_neg_ovf = b_ff[DataWidth-1] && (|b_ff[DataWidth-2:0]);

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      g_in    = g_ff;
      k_in    = k_ff;
      cnt_in  = cnt_ff;
      kind_in = kind_ff;
      nz_in   = nz_ff;
      neg_in  = neg_ff;

      if (cmd.load) begin
         a_in    = mag_a;
         b_in    = mag_b;
         x_in    = mag_a;
         y_in    = mag_b;
         k_in    = '0;
         kind_in = req_kind;
         nz_in   = (mag_a != '0) && (mag_b != '0);
         neg_in  = req_operand_a[DataWidth-1] ^ req_operand_b[DataWidth-1];
      end else if (cmd.gcd_step) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_in = x_ff >> 1;
            y_in = y_ff >> 1;
            k_in = k_ff + cnt_type'(1);
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_in = diff_xy >> 1;
         end else begin
            y_in = diff_yx >> 1;
         end
      end else if (cmd.gcd_fin) begin
         g_in   = (x_ff | y_ff) << k_ff;
         x_in   = '0;
         y_in   = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         a_in   = a_ff << 1;
         x_in   = {x_ff[DataWidth-2:0], qbit};
         y_in   = qbit ? rem_diff[DataWidth-1:0] : rem_sh[DataWidth-1:0];
         cnt_in = cnt_ff + cnt_type'(1);
      end else if (cmd.mul_init) begin
         y_in   = '0;
         cnt_in = '0;
      end else if (cmd.mul_step) begin
         y_in   = mul_sum[DataWidth:1];
         b_in   = {mul_sum[0], b_ff[DataWidth-1:1]};
         cnt_in = cnt_ff + cnt_type'(1);
      end
   end

   always_comb begin
      value_in = value_ff;
      ovf_in   = ovf_ff;
      valid_in = valid_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         if (!kind_ff) begin
            value_in = g_ff;
            ovf_in   = 1'b0;
         end else if (!nz_ff) begin
            value_in = '0;
            ovf_in   = 1'b0;
         end else begin
            value_in = neg_ff ? word_type'(-b_ff) : b_ff;
            // high product half nonzero means the lcm left 64 bits altogether
            ovf_in   = (|y_ff) || (neg_ff ? prod_neg_ovf : b_ff[DataWidth-1]);
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      g_ff     <= g_in;
      k_ff     <= k_in;
      cnt_ff   <= cnt_in;
      kind_ff  <= kind_in;
      nz_ff    <= nz_in;
      neg_ff   <= neg_in;
      value_ff <= value_in;
      ovf_ff   <= ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign sts.gcd_done = (x_ff == '0) || (y_ff == '0);
   assign sts.lcm_path = kind_ff && nz_ff;
   assign sts.cnt_last = (cnt_ff == cnt_type'(DataWidth - 1));
   assign sts.out_free = !valid_ff || rsp_tready;

   assign rsp_tvalid   = valid_ff;
   assign rsp_value    = value_ff;
   assign rsp_overflow = ovf_ff;

endmodule
`default_nettype wire

### rtl/core/gcd_lcm_unit.sv
// Gcd / lcm unit: one signed 64-bit operand pair in, one result out. The gcd is found by a
// binary shift-subtract loop that removes at least one operand bit per cycle and takes fewer
// steps for small operands, then the result is formed; an lcm then finds |a| / gcd in a
// one-bit-per-cycle restoring divider, takes a setup step and multiplies in a shift-add
// multiplier. One item is in flight at a time; the result sits in an output register, so
// the next item is accepted as soon as the sequencer has handed the result over, even if
// the consumer has not yet taken it. A result still waiting when the next one is ready
// holds the sequencer until the consumer takes it. The input is closed while reset is held.
`default_nettype none
module gcd_lcm_unit (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic [127:0]   req_tdata,  // operand_a [63:0], operand_b [127:64]
   input  wire logic           req_tuser,  // kind: 0 gcd, 1 lcm
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic [63:0]         rsp_tdata,  // value [63:0]
   output logic                rsp_tuser   // overflow
);
   import glu_pkg::*;

   cmd_type    cmd;
   status_type sts;

   glu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   glu_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_kind      (req_tuser),
      .req_operand_a (req_tdata[63:0]),
      .req_operand_b (req_tdata[127:64]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_value     (rsp_tdata),
      .rsp_overflow  (rsp_tuser)
   );

   // only one datapath operation per cycle
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.gcd_step, cmd.gcd_fin, cmd.div_step,
                cmd.mul_init, cmd.mul_step, cmd.emit}))
      else $error("conflicting datapath commands");

   // a result is never written over one still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result overwritten");

   // an accepted item keeps the input closed the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input reopened while busy");

   // every hand-over shows up on the result channel
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("result lost");

endmodule
`default_nettype wire
